>>> sv/cfdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdf_pkg
// Shared types, constants and the byte-wide CRC16 step for the framed
// byte stream deframer.
// ----------------------------------------------------------------------------
package cfdf_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned FRAME_OVERHEAD  = 16;
    localparam int unsigned HEADER_BYTES    = 12;
    localparam logic [16:0] MAX_PAYLOAD     = 17'(MAX_FRAME_BYTES - FRAME_OVERHEAD);

    localparam logic [7:0]  SOF_FIRST  = 8'hAA;
    localparam logic [7:0]  SOF_SECOND = 8'h55;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Event codes carried on event_kind
    localparam logic [2:0] EV_PAYLOAD = 3'd0;
    localparam logic [2:0] EV_GOOD    = 3'd1;
    localparam logic [2:0] EV_CRC     = 3'd2;
    localparam logic [2:0] EV_VERSION = 3'd3;
    localparam logic [2:0] EV_LENGTH  = 3'd4;

    // Configuration register indexes
    localparam logic CFG_EXPECTED_VERSION = 1'b0;
    localparam logic CFG_GAP_CHECKED_TYPE = 1'b1;

    typedef enum logic [2:0] {
        PH_SOF1 = 3'd0,
        PH_SOF2 = 3'd1,
        PH_HDR  = 3'd2,
        PH_PAY  = 3'd3,
        PH_CRC1 = 3'd4,
        PH_CRC2 = 3'd5
    } phase_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  data_byte;
        logic [7:0]  frame_type;
        logic [15:0] payload_length;
        logic [31:0] sequence_number;
        logic [31:0] timestamp_ms;
        logic        seq_gap;
        logic [31:0] crc_error_total;
        logic [31:0] gap_total;
        logic [31:0] version_error_total;
        logic [31:0] length_error_total;
    } res_t;

    // CRC16-CCITT-FALSE over one byte, MSB first
    function automatic logic [15:0] crc_add(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> sv/cfdf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfdf_parser
// Frame parser state: start-byte hunt, header capture, payload pass-through,
// CRC check, sequence gap check and error counters. One byte per step.
// ----------------------------------------------------------------------------
module cfdf_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    input  logic [7:0]        expected_version,
    input  logic [7:0]        gap_checked_type,
    output logic              emit,
    output cfdf_pkg::res_t    res
);
    import cfdf_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] sequence_reg, sequence_next;
    logic [31:0] time_reg, time_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [31:0] last_seq_reg, last_seq_next;
    logic        last_seq_valid_reg, last_seq_valid_next;
    logic [31:0] crc_err_reg, crc_err_next;
    logic [31:0] gap_cnt_reg, gap_cnt_next;
    logic [31:0] ver_err_reg, ver_err_next;
    logic [31:0] len_err_reg, len_err_next;

    logic [15:0] crc_step;
    logic [2:0]  kind;
    logic [7:0]  data_out;
    logic        gap;

    assign crc_step = crc_add(crc_reg, byte_in);

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        payload_count_next  = payload_count_reg;
        length_next         = length_reg;
        version_next        = version_reg;
        type_next           = type_reg;
        sequence_next       = sequence_reg;
        time_next           = time_reg;
        crc_next            = crc_reg;
        crc_low_next        = crc_low_reg;
        last_seq_next       = last_seq_reg;
        last_seq_valid_next = last_seq_valid_reg;
        crc_err_next        = crc_err_reg;
        gap_cnt_next        = gap_cnt_reg;
        ver_err_next        = ver_err_reg;
        len_err_next        = len_err_reg;
        emit                = 1'b0;
        kind                = EV_PAYLOAD;
        data_out            = 8'h00;
        gap                 = 1'b0;

        unique case (phase_reg)
            PH_SOF1:
            begin
                if (byte_in == SOF_FIRST)
                    phase_next = PH_SOF2;
            end
            PH_SOF2:
            begin
                // a repeated first start byte keeps the hunt armed
                if (byte_in == SOF_SECOND)
                begin
                    header_count_next = 4'd0;
                    crc_next          = CRC_INIT;
                    phase_next        = PH_HDR;
                end
                else if (byte_in != SOF_FIRST)
                    phase_next = PH_SOF1;
            end
            PH_HDR:
            begin
                crc_next = crc_step;
                unique case (header_count_reg)
                    4'd0:    version_next         = byte_in;
                    4'd1:    type_next            = byte_in;
                    4'd2:    length_next[7:0]     = byte_in;
                    4'd3:    length_next[15:8]    = byte_in;
                    4'd4:    sequence_next[7:0]   = byte_in;
                    4'd5:    sequence_next[15:8]  = byte_in;
                    4'd6:    sequence_next[23:16] = byte_in;
                    4'd7:    sequence_next[31:24] = byte_in;
                    4'd8:    time_next[7:0]       = byte_in;
                    4'd9:    time_next[15:8]      = byte_in;
                    4'd10:   time_next[23:16]     = byte_in;
                    4'd11:   time_next[31:24]     = byte_in;
                    default: ;
                endcase
                header_count_next = header_count_reg + 4'd1;
                if (header_count_reg >= 4'(HEADER_BYTES - 1))
                begin
                    priority if (version_next != expected_version)
                    begin
                        ver_err_next       = ver_err_reg + 32'd1;
                        phase_next         = PH_SOF1;
                        header_count_next  = 4'd0;
                        payload_count_next = 16'd0;
                        emit               = 1'b1;
                        kind               = EV_VERSION;
                    end
                    else if ({1'b0, length_next} > MAX_PAYLOAD)
                    begin
                        len_err_next       = len_err_reg + 32'd1;
                        phase_next         = PH_SOF1;
                        header_count_next  = 4'd0;
                        payload_count_next = 16'd0;
                        emit               = 1'b1;
                        kind               = EV_LENGTH;
                    end
                    else
                    begin
                        payload_count_next = 16'd0;
                        phase_next = (length_next == 16'd0) ? PH_CRC1 : PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                crc_next           = crc_step;
                payload_count_next = payload_count_reg + 16'd1;
                if (payload_count_next == length_reg)
                    phase_next = PH_CRC1;
                emit     = 1'b1;
                kind     = EV_PAYLOAD;
                data_out = byte_in;
            end
            PH_CRC1:
            begin
                crc_low_next = byte_in;
                phase_next   = PH_CRC2;
            end
            PH_CRC2:
            begin
                phase_next         = PH_SOF1;
                header_count_next  = 4'd0;
                payload_count_next = 16'd0;
                emit               = 1'b1;
                if ({byte_in, crc_low_reg} != crc_reg)
                begin
                    crc_err_next = crc_err_reg + 32'd1;
                    kind         = EV_CRC;
                end
                else
                begin
                    kind = EV_GOOD;
                    if (type_reg == gap_checked_type)
                    begin
                        if (last_seq_valid_reg && sequence_reg != (last_seq_reg + 32'd1)
                            && sequence_reg != 32'd0)
                        begin
                            gap          = 1'b1;
                            gap_cnt_next = gap_cnt_reg + 32'd1;
                        end
                        last_seq_next       = sequence_reg;
                        last_seq_valid_next = 1'b1;
                    end
                end
            end
            default:
            begin
                // unused phase code: drop the beat and hunt again
                phase_next         = PH_SOF1;
                header_count_next  = 4'd0;
                payload_count_next = 16'd0;
            end
        endcase
    end

    // Results carry the state as it stands after this beat
    always_comb
    begin
        res.event_kind          = kind;
        res.data_byte           = data_out;
        res.frame_type          = type_next;
        res.payload_length      = length_next;
        res.sequence_number     = sequence_next;
        res.timestamp_ms        = time_next;
        res.seq_gap             = gap;
        res.crc_error_total     = crc_err_next;
        res.gap_total           = gap_cnt_next;
        res.version_error_total = ver_err_next;
        res.length_error_total  = len_err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_SOF1;
            header_count_reg   <= 4'd0;
            payload_count_reg  <= 16'd0;
            length_reg         <= 16'd0;
            version_reg        <= 8'd0;
            type_reg           <= 8'd0;
            sequence_reg       <= 32'd0;
            time_reg           <= 32'd0;
            crc_reg            <= CRC_INIT;
            crc_low_reg        <= 8'd0;
            last_seq_reg       <= 32'd0;
            last_seq_valid_reg <= 1'b0;
            crc_err_reg        <= 32'd0;
            gap_cnt_reg        <= 32'd0;
            ver_err_reg        <= 32'd0;
            len_err_reg        <= 32'd0;
        end
        else if (step)
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            payload_count_reg  <= payload_count_next;
            length_reg         <= length_next;
            version_reg        <= version_next;
            type_reg           <= type_next;
            sequence_reg       <= sequence_next;
            time_reg           <= time_next;
            crc_reg            <= crc_next;
            crc_low_reg        <= crc_low_next;
            last_seq_reg       <= last_seq_next;
            last_seq_valid_reg <= last_seq_valid_next;
            crc_err_reg        <= crc_err_next;
            gap_cnt_reg        <= gap_cnt_next;
            ver_err_reg        <= ver_err_next;
            len_err_reg        <= len_err_next;
        end
    end

    // A payload beat only arrives while fewer than the declared bytes are in
    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_PAY |-> payload_count_reg < length_reg)
        else $error("payload count overran declared length");

    // Header index never runs past the header while in the header phase
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR |-> header_count_reg < 4'(HEADER_BYTES))
        else $error("header index out of range");

    // A gap is only flagged on a good frame
    assert property (@(posedge clk) disable iff (!rst_n)
        step && gap |-> emit && kind == EV_GOOD)
        else $error("sequence gap outside a good frame");

endmodule

>>> sv/crc_checked_frame_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_deframer_unit
// Byte-serial deframer for AA 55 framed packets with a 12-byte header and a
// CRC16-CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Takes one received byte per beat, one beat per clock when the output side
// keeps up. A byte is captured in an input register, parsed once the result
// register is free or draining, and any event it raises is then registered
// in the result register that drives the outputs. Header
// bytes, start bytes and the low CRC byte raise no event; each payload byte
// and each end of frame or header error raises exactly one. Configuration
// writes take effect on the next clock and belong between frames.
// ----------------------------------------------------------------------------
module crc_checked_frame_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  frame_type,
    output logic [15:0] payload_length,
    output logic [31:0] sequence_number,
    output logic [31:0] timestamp_ms,
    output logic        seq_gap,
    output logic [31:0] crc_error_total,
    output logic [31:0] gap_total,
    output logic [31:0] version_error_total,
    output logic [31:0] length_error_total
);
    import cfdf_pkg::*;

    logic [7:0] exp_version_reg, exp_version_next;
    logic [7:0] gap_type_reg, gap_type_next;
    logic [7:0] byte_reg;
    logic       byte_valid_reg, byte_valid_next;
    logic       res_valid_reg, res_valid_next;
    res_t       res_reg;
    res_t       parse_res;
    logic       parse_emit;
    logic       advance;

    // Parse the held byte whenever the result register is free or draining
    assign advance  = byte_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || advance;

    cfdf_parser u_parser (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .byte_in          (byte_reg),
        .expected_version (exp_version_reg),
        .gap_checked_type (gap_type_reg),
        .emit             (parse_emit),
        .res              (parse_res)
    );

    always_comb
    begin
        exp_version_next = exp_version_reg;
        gap_type_next    = gap_type_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_EXPECTED_VERSION: exp_version_next = cfg_data;
                CFG_GAP_CHECKED_TYPE: gap_type_next    = cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (in_valid && in_ready)
            byte_valid_next = 1'b1;
        else if (advance)
            byte_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = parse_emit;
        else if (out_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_version_reg <= 8'd1;
            gap_type_reg    <= 8'd1;
            byte_valid_reg  <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            exp_version_reg <= exp_version_next;
            gap_type_reg    <= gap_type_next;
            byte_valid_reg  <= byte_valid_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Payload registers: load on capture only
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
        if (advance && parse_emit)
            res_reg <= parse_res;
    end

    assign out_valid           = res_valid_reg;
    assign event_kind          = res_reg.event_kind;
    assign data_byte           = res_reg.data_byte;
    assign frame_type          = res_reg.frame_type;
    assign payload_length      = res_reg.payload_length;
    assign sequence_number     = res_reg.sequence_number;
    assign timestamp_ms        = res_reg.timestamp_ms;
    assign seq_gap             = res_reg.seq_gap;
    assign crc_error_total     = res_reg.crc_error_total;
    assign gap_total           = res_reg.gap_total;
    assign version_error_total = res_reg.version_error_total;
    assign length_error_total  = res_reg.length_error_total;

    // An empty result stage never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> in_ready)
        else $error("input stalled with result stage empty");

    // Only payload beats carry a data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_PAYLOAD |-> data_byte == 8'h00)
        else $error("data byte set on a non-payload event");

    // Payload beats only come from frames with an accepted length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_PAYLOAD |->
            payload_length != 16'd0 && {1'b0, payload_length} <= MAX_PAYLOAD)
        else $error("payload beat from a rejected header");

    // Event codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_kind <= EV_LENGTH)
        else $error("undefined event code");

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the AA 55 framed byte deframer with CRC16 trailer.
// ----------------------------------------------------------------------------
// A short table of hand-written bytes exercises start hunting and both
// header errors. Random frames follow: mostly well-formed, with random
// content, bad CRCs, wrong versions, oversize lengths, sequence jumps, stray
// bytes and cut-off frames, under several register settings. Every event is
// checked field by field against an in-bench model of the parser. The sender
// pauses between bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    import cfdf_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 5;
    localparam int PHASE_BYTES  = 390;
    localparam int TABLE_ROWS   = 30;
    localparam logic [3:0] NO_CHECK = 4'h0;

    // {checked, event kind, byte}; the kind is only meaningful when checked
    localparam logic [11:0] STIM_TABLE [TABLE_ROWS] = '{
        {NO_CHECK, 8'h55},
        {NO_CHECK, 8'hAA}, {NO_CHECK, 8'hAA}, {NO_CHECK, 8'h55},
        {NO_CHECK, 8'h00}, {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF},
        {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF},
        {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF},
        {1'b1, EV_VERSION, 8'hFF},
        {NO_CHECK, 8'hAA}, {NO_CHECK, 8'h55},
        {NO_CHECK, 8'h01}, {NO_CHECK, 8'h00}, {NO_CHECK, 8'hFF}, {NO_CHECK, 8'hFF},
        {NO_CHECK, 8'h00}, {NO_CHECK, 8'h00}, {NO_CHECK, 8'h00}, {NO_CHECK, 8'h00},
        {NO_CHECK, 8'h00}, {NO_CHECK, 8'h00}, {NO_CHECK, 8'h00},
        {1'b1, EV_LENGTH, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [31:0] sequence_number;
    logic [31:0] timestamp_ms;
    logic        seq_gap;
    logic [31:0] crc_error_total;
    logic [31:0] gap_total;
    logic [31:0] version_error_total;
    logic [31:0] length_error_total;

    // travels with rx_byte: a table row whose event kind is written out
    logic        rx_checked;
    logic [2:0]  rx_kind;

    // parser model
    logic [7:0]  want_version = 8'd1;
    logic [7:0]  watched_type = 8'd1;
    phase_t      parse_state = PH_SOF1;
    logic [3:0]  hdr_idx = '0;
    logic [15:0] pay_cnt = '0;
    logic [15:0] len_seen = '0;
    logic [7:0]  ver_seen = '0;
    logic [7:0]  type_seen = '0;
    logic [31:0] seq_seen = '0;
    logic [31:0] stamp_seen = '0;
    logic [15:0] crc_acc = CRC_INIT;
    logic [7:0]  crc_lo = '0;
    logic [31:0] prev_seq = '0;
    logic        prev_seq_ok = 1'b0;
    logic [31:0] crc_errs = '0;
    logic [31:0] gap_errs = '0;
    logic [31:0] ver_errs = '0;
    logic [31:0] len_errs = '0;

    res_t        expected_events[$];
    logic [7:0]  frame_q[$];
    int          bytes_sent = 0;
    int          burst_left = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          ready_pct = 100;
    int          ready_left = 0;

    crc_checked_frame_deframer_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .rx_byte             (rx_byte),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .event_kind          (event_kind),
        .data_byte           (data_byte),
        .frame_type          (frame_type),
        .payload_length      (payload_length),
        .sequence_number     (sequence_number),
        .timestamp_ms        (timestamp_ms),
        .seq_gap             (seq_gap),
        .crc_error_total     (crc_error_total),
        .gap_total           (gap_total),
        .version_error_total (version_error_total),
        .length_error_total  (length_error_total)
    );

    always #10 clk = ~clk;

    // bitwise form of the CRC16 step, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic res_t event_snapshot(input logic [2:0] kind, input logic [7:0] data,
                                            input logic gap);
        res_t ev;
        ev.event_kind          = kind;
        ev.data_byte           = data;
        ev.frame_type          = type_seen;
        ev.payload_length      = len_seen;
        ev.sequence_number     = seq_seen;
        ev.timestamp_ms        = stamp_seen;
        ev.seq_gap             = gap;
        ev.crc_error_total     = crc_errs;
        ev.gap_total           = gap_errs;
        ev.version_error_total = ver_errs;
        ev.length_error_total  = len_errs;
        return ev;
    endfunction

    task automatic rewind_parser();
        parse_state = PH_SOF1;
        hdr_idx     = '0;
        pay_cnt     = '0;
    endtask

    // advance the parser model by one byte; fired tells whether an event results
    task automatic deframe_byte(input logic [7:0] b, output logic fired, output res_t ev);
        logic gap;
        fired = 1'b0;
        ev    = '0;
        gap   = 1'b0;
        case (parse_state)
            PH_SOF1:
            begin
                if (b == SOF_FIRST)
                    parse_state = PH_SOF2;
            end
            PH_SOF2:
            begin
                if (b == SOF_SECOND)
                begin
                    hdr_idx     = '0;
                    crc_acc     = CRC_INIT;
                    parse_state = PH_HDR;
                end
                else if (b != SOF_FIRST)
                    parse_state = PH_SOF1;
            end
            PH_HDR:
            begin
                crc_acc = crc16_byte(crc_acc, b);
                // multi-byte fields arrive low byte first: shift in from the top
                if (hdr_idx == 4'd0)
                    ver_seen = b;
                else if (hdr_idx == 4'd1)
                    type_seen = b;
                else if (hdr_idx <= 4'd3)
                    len_seen = {b, len_seen[15:8]};
                else if (hdr_idx <= 4'd7)
                    seq_seen = {b, seq_seen[31:8]};
                else
                    stamp_seen = {b, stamp_seen[31:8]};
                hdr_idx = hdr_idx + 4'd1;
                if (hdr_idx == HEADER_BYTES[3:0])
                begin
                    if (ver_seen != want_version)
                    begin
                        ver_errs = ver_errs + 1;
                        rewind_parser();
                        fired = 1'b1;
                        ev    = event_snapshot(EV_VERSION, 8'h00, 1'b0);
                    end
                    else if ({1'b0, len_seen} > MAX_PAYLOAD)
                    begin
                        len_errs = len_errs + 1;
                        rewind_parser();
                        fired = 1'b1;
                        ev    = event_snapshot(EV_LENGTH, 8'h00, 1'b0);
                    end
                    else
                    begin
                        pay_cnt     = '0;
                        parse_state = (len_seen == 16'd0) ? PH_CRC1 : PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                crc_acc = crc16_byte(crc_acc, b);
                pay_cnt = pay_cnt + 16'd1;
                if (pay_cnt == len_seen)
                    parse_state = PH_CRC1;
                fired = 1'b1;
                ev    = event_snapshot(EV_PAYLOAD, b, 1'b0);
            end
            PH_CRC1:
            begin
                crc_lo      = b;
                parse_state = PH_CRC2;
            end
            PH_CRC2:
            begin
                rewind_parser();
                fired = 1'b1;
                if ({b, crc_lo} != crc_acc)
                begin
                    crc_errs = crc_errs + 1;
                    ev       = event_snapshot(EV_CRC, 8'h00, 1'b0);
                end
                else
                begin
                    if (type_seen == watched_type)
                    begin
                        if (prev_seq_ok && seq_seen != prev_seq + 32'd1 && seq_seen != 32'd0)
                        begin
                            gap      = 1'b1;
                            gap_errs = gap_errs + 1;
                        end
                        prev_seq    = seq_seen;
                        prev_seq_ok = 1'b1;
                    end
                    ev = event_snapshot(EV_GOOD, 8'h00, gap);
                end
            end
            default:
                rewind_parser();
        endcase
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_byte(input logic [7:0] b, input logic checked, input logic [2:0] kind);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        rx_byte    <= b;
        rx_checked <= checked;
        rx_kind    <= kind;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // one chunk of random traffic: stray bytes or a frame, sometimes broken
    task automatic random_chunk();
        int          r;
        int          cut;
        logic [7:0]  hdr [12];
        logic [7:0]  ver;
        logic [7:0]  typ;
        logic [7:0]  pb;
        logic [15:0] len;
        logic [15:0] crc;
        logic [31:0] seq;
        logic [31:0] stamp;
        frame_q.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 6))
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    frame_q.push_back(SOF_FIRST);
                else if (r == 1)
                    frame_q.push_back(SOF_SECOND);
                else
                    frame_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            ver = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : want_version;
            typ = ($urandom_range(0, 4) < 3) ? watched_type : 8'($urandom_range(0, 255));
            // keep most payloads short; only a few reach the ceiling or go over it
            r = $urandom_range(0, 199);
            if (r < 30)
                len = 16'd0;
            else if (r < 160)
                len = 16'($urandom_range(1, 6));
            else if (r < 190)
                len = 16'($urandom_range(7, 40));
            else if (r < 193)
                len = MAX_PAYLOAD[15:0];
            else if (r < 196)
                len = 16'($urandom_range(41, 239));
            else if (r < 198)
                len = MAX_PAYLOAD[15:0] + 16'd1;
            else
                len = 16'($urandom_range(242, 65535));
            r = $urandom_range(0, 9);
            if (r < 6)
                seq = prev_seq + 32'd1;
            else if (r == 6)
                seq = 32'd0;
            else if (r == 7)
                seq = $urandom;
            else if (r == 8)
                seq = 32'hFFFF_FFFF;
            else
                seq = prev_seq;
            stamp = $urandom;
            hdr = '{ver, typ, len[7:0], len[15:8],
                    seq[7:0], seq[15:8], seq[23:16], seq[31:24],
                    stamp[7:0], stamp[15:8], stamp[23:16], stamp[31:24]};
            if ($urandom_range(0, 9) == 0)
                frame_q.push_back(SOF_FIRST);
            frame_q.push_back(SOF_FIRST);
            frame_q.push_back(SOF_SECOND);
            crc = CRC_INIT;
            for (int k = 0; k < 12; k++)
            begin
                frame_q.push_back(hdr[k]);
                crc = crc16_byte(crc, hdr[k]);
            end
            if ({1'b0, len} <= MAX_PAYLOAD)
            begin
                for (int k = 0; k < len; k++)
                begin
                    pb = 8'($urandom_range(0, 255));
                    frame_q.push_back(pb);
                    crc = crc16_byte(crc, pb);
                end
                if ($urandom_range(0, 9) == 0)
                    crc = crc ^ (16'h0001 << $urandom_range(0, 15));
                frame_q.push_back(crc[7:0]);
                frame_q.push_back(crc[15:8]);
            end
            // cut the frame short now and then
            if ($urandom_range(0, 19) == 0)
            begin
                cut = $urandom_range(3, frame_q.size() - 1);
                while (frame_q.size() > cut)
                    void'(frame_q.pop_back());
            end
        end
        foreach (frame_q[k])
            send_byte(frame_q[k], 1'b0, EV_PAYLOAD);
    endtask

    // called at a falling edge with nothing in flight
    task automatic set_config(input logic [7:0] ver, input logic [7:0] typ);
        cfg_write <= 1'b1;
        cfg_index <= CFG_EXPECTED_VERSION;
        cfg_data  <= ver;
        @(negedge clk);
        want_version = ver;
        cfg_index <= CFG_GAP_CHECKED_TYPE;
        cfg_data  <= typ;
        @(negedge clk);
        watched_type = typ;
        cfg_write <= 1'b0;
    endtask

    // receiver: ready odds change from one stretch to the next
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            case ($urandom_range(0, 3))
                0: ready_pct = 100;
                1: ready_pct = 75;
                2: ready_pct = 50;
                default: ready_pct = 12;
            endcase
            ready_left = $urandom_range(4, 40);
        end
        ready_left--;
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
    end

    always @(posedge clk)
    begin : scoreboard
        logic fired;
        res_t ev;
        res_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte, fired, ev);
                if (rx_checked)
                begin
                    if (!fired)
                        ev = event_snapshot(rx_kind, 8'h00, 1'b0);
                    ev.event_kind = rx_kind;
                    fired = 1'b1;
                end
                if (fired)
                    expected_events.push_back(ev);
            end
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("event_kind: unexpected beat, kind %0d", event_kind);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", want.event_kind, event_kind);
                    compare_field("data_byte", want.data_byte, data_byte);
                    compare_field("frame_type", want.frame_type, frame_type);
                    compare_field("payload_length", want.payload_length, payload_length);
                    compare_field("sequence_number", want.sequence_number, sequence_number);
                    compare_field("timestamp_ms", want.timestamp_ms, timestamp_ms);
                    compare_field("seq_gap", want.seq_gap, seq_gap);
                    compare_field("crc_error_total", want.crc_error_total, crc_error_total);
                    compare_field("gap_total", want.gap_total, gap_total);
                    compare_field("version_error_total", want.version_error_total,
                                  version_error_total);
                    compare_field("length_error_total", want.length_error_total,
                                  length_error_total);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int target;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'h00;
        rx_checked = 1'b0;
        rx_kind    = EV_PAYLOAD;
        cfg_write  = 1'b0;
        cfg_index  = CFG_EXPECTED_VERSION;
        cfg_data   = 8'h00;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < TABLE_ROWS; k++)
            send_byte(STIM_TABLE[k][7:0], STIM_TABLE[k][11], STIM_TABLE[k][10:8]);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                // drain, then allow for bytes still in the pipe that raise no event
                in_valid <= 1'b0;
                while (expected_events.size() != 0)
                    @(negedge clk);
                repeat (4) @(negedge clk);
                case (p)
                    1: set_config(8'h00, 8'h00);
                    2: set_config(8'hFF, 8'hFF);
                    3: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                    default: set_config(8'h01, 8'($urandom_range(0, 255)));
                endcase
            end
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target)
                random_chunk();
        end

        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && expected_events.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
